// ----- design/lcav_pkg.sv -----
// lcav_pkg: widths, payload types and the square root step shared by the
// lattice cell area and volume pipeline. No dependencies.
package lcav_pkg;

    localparam int COORD_W     = 16;
    localparam int CROSS_W     = 32;
    localparam int SQR_W       = 62;
    localparam int SQ_W        = 64;
    localparam int ROOT_W      = 32;
    localparam int REM_W       = 36;
    localparam int VPROD_W     = 48;
    localparam int VOL_W       = 49;
    localparam int AREA_W      = 34;
    localparam int VOLUME_W    = 48;
    localparam int LANES       = 3;
    localparam int ROOT_STAGES = SQ_W / 2;
    localparam int TDATA_IN_W  = 9 * COORD_W;
    localparam int TDATA_OUT_W = ((AREA_W + VOLUME_W + 7) / 8) * 8;

    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] z;
    } vec_t;

    typedef struct packed {
        logic signed [CROSS_W-1:0] x;
        logic signed [CROSS_W-1:0] y;
        logic signed [CROSS_W-1:0] z;
    } cross_t;

    // partial products of one cross product
    typedef struct packed {
        logic signed [CROSS_W-1:0] yz;
        logic signed [CROSS_W-1:0] zy;
        logic signed [CROSS_W-1:0] zx;
        logic signed [CROSS_W-1:0] xz;
        logic signed [CROSS_W-1:0] xy;
        logic signed [CROSS_W-1:0] yx;
    } prod_t;

    typedef struct packed {
        logic [REM_W-1:0]  rem;
        logic [ROOT_W-1:0] root;
        logic [SQ_W-1:0]   rad;
    } root_lane_t;

    function automatic prod_t cross_prod(vec_t p, vec_t q);
        prod_t r;
        r.yz = p.y * q.z;
        r.zy = p.z * q.y;
        r.zx = p.z * q.x;
        r.xz = p.x * q.z;
        r.xy = p.x * q.y;
        r.yx = p.y * q.x;
        return r;
    endfunction

    // each difference is known to fit in CROSS_W bits
    function automatic cross_t cross_diff(prod_t d);
        cross_t r;
        r.x = d.yz - d.zy;
        r.y = d.zx - d.xz;
        r.z = d.xy - d.yx;
        return r;
    endfunction

    // one restoring root step: brings in the next two radicand bits
    function automatic root_lane_t root_step(root_lane_t s);
        logic [REM_W-1:0] shifted;
        logic [REM_W-1:0] trial;
        root_lane_t r;
        shifted = {s.rem[REM_W-3:0], s.rad[SQ_W-1 -: 2]};
        trial   = {{(REM_W-ROOT_W-2){1'b0}}, s.root, 2'b01};
        r.rad   = {s.rad[SQ_W-3:0], 2'b00};
        if (shifted >= trial)
        begin
            r.rem  = shifted - trial;
            r.root = {s.root[ROOT_W-2:0], 1'b1};
        end
        else
        begin
            r.rem  = shifted;
            r.root = {s.root[ROOT_W-2:0], 1'b0};
        end
        return r;
    endfunction

endpackage

// ----- design/lcav_cross.sv -----
// lcav_cross: two pipeline stages that form a x b, b x c and c x a.
// Stage one holds the partial products, stage two the differences. Uses lcav_pkg.
module lcav_cross (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  lcav_pkg::vec_t  a,
    input  lcav_pkg::vec_t  b,
    input  lcav_pkg::vec_t  c,
    output logic            out_valid,
    input  logic            out_ready,
    output lcav_pkg::cross_t ab,
    output lcav_pkg::cross_t bc,
    output lcav_pkg::cross_t ca,
    output lcav_pkg::vec_t  a_out
);

    logic            v1_reg;
    logic            v2_reg;
    logic            rdy1;
    logic            rdy2;
    lcav_pkg::prod_t ab_p_reg;
    lcav_pkg::prod_t bc_p_reg;
    lcav_pkg::prod_t ca_p_reg;
    lcav_pkg::vec_t  a1_reg;
    lcav_pkg::cross_t ab_reg;
    lcav_pkg::cross_t bc_reg;
    lcav_pkg::cross_t ca_reg;
    lcav_pkg::vec_t  a2_reg;

    assign rdy2     = !v2_reg || out_ready;
    assign rdy1     = !v1_reg || rdy2;
    assign in_ready = rdy1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            if (rdy1)
                v1_reg <= in_valid;
            if (rdy2)
                v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy1 && in_valid)
        begin
            ab_p_reg <= lcav_pkg::cross_prod(a, b);
            bc_p_reg <= lcav_pkg::cross_prod(b, c);
            ca_p_reg <= lcav_pkg::cross_prod(c, a);
            a1_reg   <= a;
        end
        if (rdy2 && v1_reg)
        begin
            ab_reg <= lcav_pkg::cross_diff(ab_p_reg);
            bc_reg <= lcav_pkg::cross_diff(bc_p_reg);
            ca_reg <= lcav_pkg::cross_diff(ca_p_reg);
            a2_reg <= a1_reg;
        end
    end

    assign out_valid = v2_reg;
    assign ab        = ab_reg;
    assign bc        = bc_reg;
    assign ca        = ca_reg;
    assign a_out     = a2_reg;

endmodule

// ----- design/lcav_square.sv -----
// lcav_square: two pipeline stages that square the cross components and form
// the volume products, then sum them into radicands and a signed volume. Uses lcav_pkg.
module lcav_square (
    input  logic                                          clk,
    input  logic                                          rst_n,
    input  logic                                          in_valid,
    output logic                                          in_ready,
    input  lcav_pkg::cross_t                              ab,
    input  lcav_pkg::cross_t                              bc,
    input  lcav_pkg::cross_t                              ca,
    input  lcav_pkg::vec_t                                a,
    output logic                                          out_valid,
    input  logic                                          out_ready,
    output logic [lcav_pkg::LANES-1:0][lcav_pkg::SQ_W-1:0] rad,
    output logic signed [lcav_pkg::VOL_W-1:0]             vol
);

    typedef struct packed {
        logic [lcav_pkg::SQR_W-1:0] x;
        logic [lcav_pkg::SQR_W-1:0] y;
        logic [lcav_pkg::SQR_W-1:0] z;
    } sqr_t;

    logic                                   v3_reg;
    logic                                   v4_reg;
    logic                                   rdy3;
    logic                                   rdy4;
    lcav_pkg::cross_t                       lane_in [lcav_pkg::LANES];
    sqr_t                                   sq_next [lcav_pkg::LANES];
    sqr_t                                   sq_reg [lcav_pkg::LANES];
    logic signed [lcav_pkg::VPROD_W-1:0]    vpx_reg;
    logic signed [lcav_pkg::VPROD_W-1:0]    vpy_reg;
    logic signed [lcav_pkg::VPROD_W-1:0]    vpz_reg;
    logic [lcav_pkg::LANES-1:0][lcav_pkg::SQ_W-1:0] rad_reg;
    logic signed [lcav_pkg::VOL_W-1:0]      vol_reg;

    assign rdy4     = !v4_reg || out_ready;
    assign rdy3     = !v3_reg || rdy4;
    assign in_ready = rdy3;

    always_comb
    begin
        lane_in[0] = ab;
        lane_in[1] = bc;
        lane_in[2] = ca;
    end

    always_comb
    begin
        logic signed [lcav_pkg::SQ_W-1:0] fx;
        logic signed [lcav_pkg::SQ_W-1:0] fy;
        logic signed [lcav_pkg::SQ_W-1:0] fz;
        for (int l = 0; l < lcav_pkg::LANES; l++)
        begin
            fx = lane_in[l].x * lane_in[l].x;
            fy = lane_in[l].y * lane_in[l].y;
            fz = lane_in[l].z * lane_in[l].z;
            // squares of values below 2^31 stay below 2^62
            sq_next[l].x = fx[lcav_pkg::SQR_W-1:0];
            sq_next[l].y = fy[lcav_pkg::SQR_W-1:0];
            sq_next[l].z = fz[lcav_pkg::SQR_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            if (rdy3)
                v3_reg <= in_valid;
            if (rdy4)
                v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy3 && in_valid)
        begin
            for (int l = 0; l < lcav_pkg::LANES; l++)
                sq_reg[l] <= sq_next[l];
            vpx_reg <= a.x * bc.x;
            vpy_reg <= a.y * bc.y;
            vpz_reg <= a.z * bc.z;
        end
        if (rdy4 && v3_reg)
        begin
            for (int l = 0; l < lcav_pkg::LANES; l++)
                rad_reg[l] <= lcav_pkg::SQ_W'(sq_reg[l].x) + lcav_pkg::SQ_W'(sq_reg[l].y)
                            + lcav_pkg::SQ_W'(sq_reg[l].z);
            vol_reg <= lcav_pkg::VOL_W'(vpx_reg) + lcav_pkg::VOL_W'(vpy_reg)
                     + lcav_pkg::VOL_W'(vpz_reg);
        end
    end

    assign out_valid = v4_reg;
    assign rad       = rad_reg;
    assign vol       = vol_reg;

endmodule

// ----- design/lcav_root.sv -----
// lcav_root: pipelined floor square root of three 64-bit radicands, one root
// bit per stage, with the signed volume carried alongside. Uses lcav_pkg.
module lcav_root (
    input  logic                                            clk,
    input  logic                                            rst_n,
    input  logic                                            in_valid,
    output logic                                            in_ready,
    input  logic [lcav_pkg::LANES-1:0][lcav_pkg::SQ_W-1:0]  rad,
    input  logic signed [lcav_pkg::VOL_W-1:0]               vol,
    output logic                                            out_valid,
    input  logic                                            out_ready,
    output logic [lcav_pkg::LANES-1:0][lcav_pkg::ROOT_W-1:0] root,
    output logic signed [lcav_pkg::VOL_W-1:0]               vol_out
);

    typedef struct packed {
        lcav_pkg::root_lane_t [lcav_pkg::LANES-1:0] lane;
        logic signed [lcav_pkg::VOL_W-1:0]          vol;
    } stage_t;

    logic [lcav_pkg::ROOT_STAGES-1:0] valid_reg;
    logic [lcav_pkg::ROOT_STAGES-1:0] vin;
    logic [lcav_pkg::ROOT_STAGES:0]   rdy;
    stage_t       seed;
    stage_t       st_reg  [lcav_pkg::ROOT_STAGES];
    stage_t       st_next [lcav_pkg::ROOT_STAGES];

    always_comb
    begin
        for (int l = 0; l < lcav_pkg::LANES; l++)
        begin
            seed.lane[l].rem  = '0;
            seed.lane[l].root = '0;
            seed.lane[l].rad  = rad[l];
        end
        seed.vol = vol;
    end

    // stage k moves when it is empty or its successor moves
    assign rdy[lcav_pkg::ROOT_STAGES] = out_ready;
    for (genvar k = 0; k < lcav_pkg::ROOT_STAGES; k++)
    begin : g_ready
        assign rdy[k] = !valid_reg[k] || rdy[k+1];
        if (k == 0)
        begin : g_first
            assign vin[k] = in_valid;
        end
        else
        begin : g_rest
            assign vin[k] = valid_reg[k-1];
        end
    end

    assign in_ready = rdy[0];

    always_comb
    begin
        stage_t src;
        for (int k = 0; k < lcav_pkg::ROOT_STAGES; k++)
        begin
            src = (k == 0) ? seed : st_reg[(k == 0) ? 0 : k-1];
            for (int l = 0; l < lcav_pkg::LANES; l++)
                st_next[k].lane[l] = lcav_pkg::root_step(src.lane[l]);
            st_next[k].vol = src.vol;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else
        begin
            for (int k = 0; k < lcav_pkg::ROOT_STAGES; k++)
                if (rdy[k])
                    valid_reg[k] <= vin[k];
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < lcav_pkg::ROOT_STAGES; k++)
            if (rdy[k] && vin[k])
                st_reg[k] <= st_next[k];
    end

    assign out_valid = valid_reg[lcav_pkg::ROOT_STAGES-1];
    always_comb
    begin
        for (int l = 0; l < lcav_pkg::LANES; l++)
            root[l] = st_reg[lcav_pkg::ROOT_STAGES-1].lane[l].root;
    end
    assign vol_out = st_reg[lcav_pkg::ROOT_STAGES-1].vol;

endmodule

// ----- design/lattice_cell_area_volume.sv -----
// lattice_cell_area_volume: top level; cross products, squares, root pipeline
// and the output register. Uses lcav_pkg, lcav_cross, lcav_square and lcav_root.
//
// Takes three Q8.8 lattice vectors per request and returns the sum of the
// three cross product magnitudes (floor roots, Q16.16) and the absolute
// triple product (Q24.24). One request is taken per clock while the output
// side keeps up. Requests pass the cross product stages, the squaring and
// summing stages, the square root stages (one root bit per stage) and the
// output register. Every stage holds its own valid bit, so empty stages fill
// up while the output is stalled. No state is kept between requests.
module lattice_cell_area_volume (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z (16 bits each)
    input  logic [lcav_pkg::TDATA_IN_W-1:0]     s_tdata,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // face_area_sum (34), cell_volume (48), zero pad (6)
    output logic [lcav_pkg::TDATA_OUT_W-1:0]    m_tdata
);

    lcav_pkg::vec_t   a;
    lcav_pkg::vec_t   b;
    lcav_pkg::vec_t   c;
    logic             cr_valid;
    logic             cr_ready;
    lcav_pkg::cross_t ab;
    lcav_pkg::cross_t bc;
    lcav_pkg::cross_t ca;
    lcav_pkg::vec_t   a_d;
    logic             sq_valid;
    logic             sq_ready;
    logic [lcav_pkg::LANES-1:0][lcav_pkg::SQ_W-1:0]   sq_rad;
    logic signed [lcav_pkg::VOL_W-1:0]                sq_vol;
    logic             rt_valid;
    logic             fin_ready;
    logic [lcav_pkg::LANES-1:0][lcav_pkg::ROOT_W-1:0] rt_root;
    logic signed [lcav_pkg::VOL_W-1:0]                rt_vol;
    logic [lcav_pkg::VOL_W-1:0]                       vol_abs;
    logic                                 out_valid_reg;
    logic [lcav_pkg::AREA_W-1:0]          area_reg;
    logic [lcav_pkg::VOLUME_W-1:0]        volume_reg;

    assign a.x = s_tdata[0*lcav_pkg::COORD_W +: lcav_pkg::COORD_W];
    assign a.y = s_tdata[1*lcav_pkg::COORD_W +: lcav_pkg::COORD_W];
    assign a.z = s_tdata[2*lcav_pkg::COORD_W +: lcav_pkg::COORD_W];
    assign b.x = s_tdata[3*lcav_pkg::COORD_W +: lcav_pkg::COORD_W];
    assign b.y = s_tdata[4*lcav_pkg::COORD_W +: lcav_pkg::COORD_W];
    assign b.z = s_tdata[5*lcav_pkg::COORD_W +: lcav_pkg::COORD_W];
    assign c.x = s_tdata[6*lcav_pkg::COORD_W +: lcav_pkg::COORD_W];
    assign c.y = s_tdata[7*lcav_pkg::COORD_W +: lcav_pkg::COORD_W];
    assign c.z = s_tdata[8*lcav_pkg::COORD_W +: lcav_pkg::COORD_W];

    lcav_cross u_cross (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .a         (a),
        .b         (b),
        .c         (c),
        .out_valid (cr_valid),
        .out_ready (cr_ready),
        .ab        (ab),
        .bc        (bc),
        .ca        (ca),
        .a_out     (a_d)
    );

    lcav_square u_square (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (cr_valid),
        .in_ready  (cr_ready),
        .ab        (ab),
        .bc        (bc),
        .ca        (ca),
        .a         (a_d),
        .out_valid (sq_valid),
        .out_ready (sq_ready),
        .rad       (sq_rad),
        .vol       (sq_vol)
    );

    lcav_root u_root (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (sq_valid),
        .in_ready  (sq_ready),
        .rad       (sq_rad),
        .vol       (sq_vol),
        .out_valid (rt_valid),
        .out_ready (fin_ready),
        .root      (rt_root),
        .vol_out   (rt_vol)
    );

    assign fin_ready = !out_valid_reg || m_tready;
    assign vol_abs   = (rt_vol < 0) ? lcav_pkg::VOL_W'(-rt_vol) : lcav_pkg::VOL_W'(rt_vol);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (fin_ready)
            out_valid_reg <= rt_valid;
    end

    always_ff @(posedge clk)
    begin
        if (fin_ready && rt_valid)
        begin
            area_reg   <= lcav_pkg::AREA_W'(rt_root[0]) + lcav_pkg::AREA_W'(rt_root[1])
                        + lcav_pkg::AREA_W'(rt_root[2]);
            volume_reg <= vol_abs[lcav_pkg::VOLUME_W-1:0];
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(lcav_pkg::TDATA_OUT_W - lcav_pkg::AREA_W - lcav_pkg::VOLUME_W){1'b0}},
                       volume_reg, area_reg};

`ifndef NO_ASSERTIONS
    // with the output register empty every stage can move, so input is open
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid |-> s_tready)
        else $error("input not ready while output register is empty");

    a_root_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rt_valid && !fin_ready |=> rt_valid && $stable(rt_root) && $stable(rt_vol))
        else $error("root stage result changed while stalled");

    a_square_hold: assert property (@(posedge clk) disable iff (!rst_n)
        sq_valid && !sq_ready |=> sq_valid && $stable(sq_rad) && $stable(sq_vol))
        else $error("square stage result changed while stalled");
`endif

endmodule

// ----- bench/tb.sv -----
// tb: self-checking bench for lattice_cell_area_volume; streams lattice cells in, predicts
// face area sum and cell volume per cell, and compares every result. Depends on lcav_pkg.
module tb;

    localparam int IDLE_LIMIT = 2000;
    localparam int TAIL_WAIT  = 45;

    typedef struct packed {
        logic [lcav_pkg::AREA_W-1:0]   area;
        logic [lcav_pkg::VOLUME_W-1:0] volume;
    } cell_measure_t;

    logic                             clk;
    logic                             rst_n;
    logic                             s_tvalid;
    logic                             s_tready;
    logic [lcav_pkg::TDATA_IN_W-1:0]  s_tdata;
    logic                             m_tvalid;
    logic                             m_tready;
    logic [lcav_pkg::TDATA_OUT_W-1:0] m_tdata;

    cell_measure_t pending_measures[$];
    int            tx_max_gap;
    int            rx_max_stall;
    int            mismatch_count;
    int            cells_sent;
    int            results_checked;
    int            idle_cycles;

    lattice_cell_area_volume u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // ---------------------------------------------------------------- prediction

    function automatic logic [63:0] square_mag(longint v);
        logic [63:0] m;
        m = (v < 0) ? 64'(-v) : 64'(v);
        return m * m;
    endfunction

    // bit-serial floor root, two radicand bits per pass
    function automatic logic [31:0] floor_root(logic [63:0] n);
        logic [63:0] rest;
        logic [63:0] acc;
        logic [63:0] probe;
        rest  = n;
        acc   = '0;
        probe = 64'h1 << 62;
        while (probe > rest)
            probe = probe >> 2;
        while (probe != 0)
        begin
            if (rest >= acc + probe)
            begin
                rest = rest - (acc + probe);
                acc  = (acc >> 1) + probe;
            end
            else
                acc = acc >> 1;
            probe = probe >> 2;
        end
        return acc[31:0];
    endfunction

    function automatic logic [31:0] face_root(longint px, longint py, longint pz,
                                              longint qx, longint qy, longint qz);
        logic [63:0] norm_sq;
        norm_sq = square_mag(py * qz - pz * qy) + square_mag(pz * qx - px * qz)
                + square_mag(px * qy - py * qx);
        return floor_root(norm_sq);
    endfunction

    function automatic cell_measure_t measure_cell(logic [lcav_pkg::TDATA_IN_W-1:0] d);
        longint        k[9];
        longint        bcx;
        longint        bcy;
        longint        bcz;
        longint        triple;
        cell_measure_t r;
        for (int i = 0; i < 9; i++)
            k[i] = longint'($signed(d[lcav_pkg::COORD_W*i +: lcav_pkg::COORD_W]));
        r.area = lcav_pkg::AREA_W'(face_root(k[0], k[1], k[2], k[3], k[4], k[5]))
               + lcav_pkg::AREA_W'(face_root(k[3], k[4], k[5], k[6], k[7], k[8]))
               + lcav_pkg::AREA_W'(face_root(k[6], k[7], k[8], k[0], k[1], k[2]));
        bcx = k[4] * k[8] - k[5] * k[7];
        bcy = k[5] * k[6] - k[3] * k[8];
        bcz = k[3] * k[7] - k[4] * k[6];
        triple = k[0] * bcx + k[1] * bcy + k[2] * bcz;
        r.volume = (triple < 0) ? lcav_pkg::VOLUME_W'(-triple) : lcav_pkg::VOLUME_W'(triple);
        return r;
    endfunction

    // ---------------------------------------------------------------- stimulus helpers

    function automatic logic [lcav_pkg::TDATA_IN_W-1:0] pack_cell(int ax, int ay, int az,
                                                                  int bx, int by, int bz,
                                                                  int cx, int cy, int cz);
        return {cz[15:0], cy[15:0], cx[15:0], bz[15:0], by[15:0], bx[15:0],
                az[15:0], ay[15:0], ax[15:0]};
    endfunction

    function automatic int rand_coord(int span);
        return int'($urandom_range(0, 2 * span - 1)) - span;
    endfunction

    function automatic int pick_extreme();
        case ($urandom_range(0, 5))
            0: return -32768;
            1: return 32767;
            2: return 0;
            3: return -1;
            4: return 1;
            default: return rand_coord(32768);
        endcase
    endfunction

    function automatic logic [lcav_pkg::TDATA_IN_W-1:0] random_cell();
        int v[9];
        int s;
        case ($urandom_range(0, 6))
            0, 1:
            begin
                for (int i = 0; i < 9; i++)
                    v[i] = rand_coord(32768);
            end
            2:
            begin
                for (int i = 0; i < 9; i++)
                    v[i] = rand_coord(512);
            end
            3:
            begin
                for (int i = 0; i < 9; i++)
                    v[i] = pick_extreme();
            end
            4:
            begin
                // b parallel to a, so a x b vanishes and so does the volume
                s = rand_coord(8);
                for (int i = 0; i < 3; i++)
                begin
                    v[i]     = rand_coord(2048);
                    v[i + 3] = s * v[i];
                    v[i + 6] = rand_coord(32768);
                end
            end
            5:
            begin
                // c in the plane of a and b: flat cell
                for (int i = 0; i < 3; i++)
                begin
                    v[i]     = rand_coord(8192);
                    v[i + 3] = rand_coord(8192);
                    v[i + 6] = v[i] - v[i + 3];
                end
            end
            default:
            begin
                // near-orthogonal basis with jitter
                for (int i = 0; i < 9; i++)
                    v[i] = rand_coord(64);
                v[0] = v[0] + 24000;
                v[4] = v[4] - 24000;
                v[8] = v[8] + 24000;
            end
        endcase
        return pack_cell(v[0], v[1], v[2], v[3], v[4], v[5], v[6], v[7], v[8]);
    endfunction

    // entered and left at a rising edge; valid stays up across back-to-back requests
    task automatic send_cell(input logic [lcav_pkg::TDATA_IN_W-1:0] d);
        int gap;
        bit taken;
        gap = $urandom_range(0, tx_max_gap);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= d;
        do
        begin
            @(negedge clk);
            taken = s_tready;
            @(posedge clk);
        end
        while (!taken);
        pending_measures.push_back(measure_cell(d));
        cells_sent++;
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_measures.size() != 0)
            @(posedge clk);
    endtask

    task automatic send_random(int count);
        for (int i = 0; i < count; i++)
            send_cell(random_cell());
    endtask

    // ---------------------------------------------------------------- tests

    task automatic test_directed();
        tx_max_gap   = 18;
        rx_max_stall = 18;
        send_cell(pack_cell(0, 0, 0, 0, 0, 0, 0, 0, 0));
        send_cell(pack_cell(256, 0, 0, 0, 256, 0, 0, 0, 256));
        // left-handed basis: negative triple product
        send_cell(pack_cell(256, 0, 0, 0, 0, 256, 0, 256, 0));
        send_cell(pack_cell(1, 0, 0, 0, 1, 0, 0, 0, 1));
        send_cell(pack_cell(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767));
        send_cell(pack_cell(-32768, -32768, -32768, -32768, -32768, -32768,
                            -32768, -32768, -32768));
        send_cell(pack_cell(-1, -1, -1, -1, -1, -1, -1, -1, -1));
        send_cell(pack_cell(-32768, 0, 0, 0, -32768, 0, 0, 0, -32768));
        send_cell(pack_cell(-32768, 0, 0, 0, -32768, 0, 0, 0, 32767));
        send_cell(pack_cell(-32768, 32767, -32768, 32767, -32768, -32768,
                            -32768, -32768, 32767));
        send_cell(pack_cell(32767, -32768, 0, -32768, -32768, 0, 0, 32767, -32768));
        send_cell(pack_cell(-32768, -32768, 32767, 32767, -32768, -32768,
                            -32768, 32767, -32768));
        // degenerate: parallel pair with a zero vector
        send_cell(pack_cell(300, -700, 1100, 600, -1400, 2200, 0, 0, 0));
        // flat cell: c = a + b
        send_cell(pack_cell(1000, 2000, -3000, -500, 4000, 700, 500, 6000, -2300));
        send_cell(pack_cell(12345, -6789, 4321, 12345, -6789, 4321, 12345, -6789, 4321));
        send_cell(pack_cell(0, 0, 32767, 0, 0, 0, -32768, 0, 0));
    endtask

    task automatic test_random_mixed();
        tx_max_gap   = 18;
        rx_max_stall = 18;
        send_random(200);
    endtask

    task automatic test_full_rate();
        tx_max_gap   = 0;
        rx_max_stall = 0;
        send_random(150);
    endtask

    task automatic test_drain_pause();
        tx_max_gap   = 3;
        rx_max_stall = 6;
        send_random(30);
        wait_drained();
        send_random(30);
    endtask

    task automatic test_output_backpressure();
        tx_max_gap   = 0;
        rx_max_stall = 18;
        send_random(120);
    endtask

    task automatic test_input_starved();
        tx_max_gap   = 18;
        rx_max_stall = 0;
        send_random(120);
    endtask

    // ---------------------------------------------------------------- result checking

    initial
    begin
        int            stall;
        bit            got;
        logic [lcav_pkg::TDATA_OUT_W-1:0] word;
        cell_measure_t want;
        cell_measure_t seen;
        m_tready = 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        m_tready <= 1'b1;
        forever
        begin
            do
            begin
                @(negedge clk);
                got  = m_tvalid;
                word = m_tdata;
                @(posedge clk);
            end
            while (!got);
            seen.area   = word[lcav_pkg::AREA_W-1:0];
            seen.volume = word[lcav_pkg::AREA_W +: lcav_pkg::VOLUME_W];
            results_checked++;
            if (pending_measures.size() == 0)
            begin
                $error("result with nothing outstanding: face_area_sum %0d cell_volume %0d",
                       seen.area, seen.volume);
                mismatch_count++;
            end
            else
            begin
                want = pending_measures.pop_front();
                if (seen.area !== want.area)
                begin
                    $error("face_area_sum: expected %0d, got %0d", want.area, seen.area);
                    mismatch_count++;
                end
                if (seen.volume !== want.volume)
                begin
                    $error("cell_volume: expected %0d, got %0d", want.volume, seen.volume);
                    mismatch_count++;
                end
            end
            stall = $urandom_range(0, rx_max_stall);
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
                m_tready <= 1'b1;
            end
        end
    end

    // no request or result moving for too long means the pipeline is stuck
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("timeout: %0d results still outstanding", pending_measures.size());
                $display("tb NOT OK");
                $finish;
            end
        end
    end

    // ---------------------------------------------------------------- main sequence

    initial
    begin
        rst_n           = 1'b0;
        s_tvalid        = 1'b0;
        s_tdata         = '0;
        tx_max_gap      = 0;
        rx_max_stall    = 0;
        mismatch_count  = 0;
        cells_sent      = 0;
        results_checked = 0;
        idle_cycles     = 0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_random_mixed();
        test_full_rate();
        test_drain_pause();
        test_output_backpressure();
        test_input_starved();

        wait_drained();
        repeat (TAIL_WAIT) @(posedge clk);

        $display("%0d lattice cells sent, %0d results compared", cells_sent, results_checked);
        $display("covered extreme and degenerate cells, random lattices, full rate and stalls");
        if (mismatch_count == 0 && pending_measures.size() == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end

endmodule

// ----- files.f -----
design/lcav_pkg.sv
design/lcav_cross.sv
design/lcav_square.sv
design/lcav_root.sv
design/lattice_cell_area_volume.sv
bench/tb.sv
